// ===== rtl/svuc_pkg.sv =====
package svuc_pkg;

	// Weight register format: unsigned Q1.16, the one integer bit so that 1.0 is reachable.
	localparam int WEIGHT_W = 17;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd38011;

	// Length is computed as a 32-bit root of a 64-bit radicand.
	localparam int ROOT_W = 32;
	localparam int RAD_W = 2 * ROOT_W;

	// Step counter covers the longest loop, the 32 root steps.
	localparam int CNT_W = 5;

	// Blend rounding: half of one LSB after the 16-bit weight shift.
	localparam int BLEND_SHIFT = 16;

	// Sequencer states.
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_MAC    = 8'b0000_0010,
		S_CHK    = 8'b0000_0100,
		S_SQRT   = 8'b0000_1000,
		S_DLOAD  = 8'b0001_0000,
		S_DIV    = 8'b0010_0000,
		S_DSTORE = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

endpackage

// ===== rtl/smoothed_vector_with_unit_clamp.sv =====
// Smoothed two-axis vector with a unit-length clamp.
// Input channel (in_valid/in_ready) carries one sample beat (new_x, new_y, signed,
// SAMPLE_BITS-1 fraction bits). Each beat is blended into the held vector per axis with
// the sustain weight, and if the blended vector is longer than one it is scaled onto
// the unit circle. The output channel (out_valid/out_ready) returns one beat per input
// beat: the new held vector and was_clamped.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the sustain weight,
// Q1.16; values above 1.0 saturate to 1.0. It is always ready.
// One multiplier does the four blend products and the two squares; one 34-bit subtractor
// then does the 32 root steps and the two per-axis divisions of SAMPLE_BITS steps each.
// The block takes one beat at a time: in_ready is high only while no sample is in work.
// A finished result waits in the output register; the next sample is accepted while it
// waits, and a stalled receiver only holds the sequencer at its final step.
// Reset clears the held vector to zero, sets the weight to 38011 (about 0.58) and
// empties the output register.
module smoothed_vector_with_unit_clamp #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_BITS-1:0]      new_x,
	input  logic signed [SAMPLE_BITS-1:0]      new_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_BITS-1:0]      smoothed_x,
	output logic signed [SAMPLE_BITS-1:0]      smoothed_y,
	output logic                               was_clamped,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [svuc_pkg::WEIGHT_W-1:0]      cfg_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int MBW = (SB > 18) ? SB : 18;
	localparam int PW = SB + MBW;
	localparam int DW = 2 * SB;
	localparam int NW = SB + svuc_pkg::ROOT_W - 1;
	localparam int SW = svuc_pkg::ROOT_W + 2;
	localparam int RW = svuc_pkg::ROOT_W;
	localparam int CW = svuc_pkg::CNT_W;

	localparam logic signed [PW-1:0] SMAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [PW-1:0] SMIN = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};
	localparam logic signed [PW-1:0] HALF = PW'(32768);
	localparam logic [DW-1:0] ONE = {2'b01, {(DW-2){1'b0}}};
	localparam logic [SB-1:0] QMAX = {1'b0, {(SB-1){1'b1}}};

	svuc_pkg::state_t state_q;
	logic [CW-1:0] cnt_q;
	logic axis_q;
	logic out_valid_q;
	logic [svuc_pkg::WEIGHT_W-1:0] weight_q;
	logic signed [SB-1:0] hx_q, hy_q;
	logic signed [SB-1:0] nx_q, ny_q;
	logic signed [PW-1:0] p_q, acc_q;
	logic [svuc_pkg::RAD_W-1:0] rad_q;
	logic [RW-1:0] rem_q, root_q;
	logic [SB-1:0] dvd_q;
	logic neg_q, clamp_q;
	logic signed [SB-1:0] sx_q, sy_q;
	logic wc_q;

	logic [svuc_pkg::WEIGHT_W-1:0] weight_new;
	logic signed [SB-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] blend_sum, blend_sh;
	logic signed [SB-1:0] blend_clip;
	logic [DW-1:0] len_sq;
	logic len_gt;
	logic [SW-1:0] sub_a, sub_b;
	logic [SW:0] sub_d;
	logic step_ge;
	logic signed [SB-1:0] axis_val;
	logic [SB-1:0] axis_mag;
	logic [NW-1:0] n_full;
	logic [SB-1:0] q_sat;
	logic [SB-1:0] q_signed;
	logic out_load;

	// Handshakes.
	assign in_ready = (state_q == svuc_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign smoothed_x = sx_q;
	assign smoothed_y = sy_q;
	assign was_clamped = wc_q;
	assign out_load = (state_q == svuc_pkg::S_OUT) && (!out_valid_q || out_ready);

	// Shared multiplier operand selection, one product per cycle of the MAC phase.
	assign weight_new = svuc_pkg::WEIGHT_ONE - weight_q;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cnt_q)
			5'd0: begin
				mul_a = hx_q;
				mul_b = MBW'($signed({1'b0, weight_q}));
			end
			5'd1: begin
				mul_a = nx_q;
				mul_b = MBW'($signed({1'b0, weight_new}));
			end
			5'd2: begin
				mul_a = hy_q;
				mul_b = MBW'($signed({1'b0, weight_q}));
			end
			5'd3: begin
				mul_a = ny_q;
				mul_b = MBW'($signed({1'b0, weight_new}));
			end
			5'd4: begin
				mul_a = hx_q;
				mul_b = MBW'(hx_q);
			end
			5'd5: begin
				mul_a = hy_q;
				mul_b = MBW'(hy_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	// Blend completion: accumulator already holds the first product plus one half LSB.
	assign blend_sum = acc_q + p_q;
	assign blend_sh = blend_sum >>> svuc_pkg::BLEND_SHIFT;
	always_comb begin
		if (blend_sh > SMAX) begin
			blend_clip = QMAX;
		end else if (blend_sh < SMIN) begin
			blend_clip = ~QMAX;
		end else begin
			blend_clip = blend_sh[SB-1:0];
		end
	end

	// Squared length against 1.0.
	assign len_sq = acc_q[DW-1:0];
	assign len_gt = len_sq > ONE;

	// Shared subtractor: a root step or a division step.
	always_comb begin
		if (state_q == svuc_pkg::S_SQRT) begin
			sub_a = {rem_q, rad_q[svuc_pkg::RAD_W-1 -: 2]};
			sub_b = {root_q, 2'b01};
		end else begin
			sub_a = {1'b0, rem_q, dvd_q[SB-1]};
			sub_b = {2'b00, root_q};
		end
	end
	assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};
	assign step_ge = !sub_d[SW];

	// Division setup: numerator is the magnitude times 2^31 plus half the root.
	assign axis_val = axis_q ? hy_q : hx_q;
	assign axis_mag = axis_val[SB-1] ? ({SB{1'b0}} - axis_val) : axis_val;
	assign n_full = {axis_mag, root_q[RW-1:1]};

	// Quotient saturation and sign.
	assign q_sat = dvd_q[SB-1] ? QMAX : dvd_q;
	assign q_signed = neg_q ? ({SB{1'b0}} - q_sat) : q_sat;

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svuc_pkg::S_IDLE;
			cnt_q <= '0;
			axis_q <= 1'b0;
			out_valid_q <= 1'b0;
			weight_q <= svuc_pkg::WEIGHT_RESET;
			hx_q <= '0;
			hy_q <= '0;
		end else begin
			if (cfg_valid) begin
				weight_q <= (cfg_data > svuc_pkg::WEIGHT_ONE) ? svuc_pkg::WEIGHT_ONE : cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				svuc_pkg::S_IDLE: begin
					if (in_valid) begin
						state_q <= svuc_pkg::S_MAC;
						cnt_q <= '0;
					end
				end
				svuc_pkg::S_MAC: begin
					cnt_q <= cnt_q + 1'b1;
					case (cnt_q)
						5'd2: hx_q <= blend_clip;
						5'd4: hy_q <= blend_clip;
						5'd6: state_q <= svuc_pkg::S_CHK;
						default: begin
						end
					endcase
				end
				svuc_pkg::S_CHK: begin
					cnt_q <= '0;
					state_q <= len_gt ? svuc_pkg::S_SQRT : svuc_pkg::S_OUT;
				end
				svuc_pkg::S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(RW - 1)) begin
						state_q <= svuc_pkg::S_DLOAD;
						axis_q <= 1'b0;
					end
				end
				svuc_pkg::S_DLOAD: begin
					cnt_q <= '0;
					state_q <= svuc_pkg::S_DIV;
				end
				svuc_pkg::S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(SB - 1)) begin
						state_q <= svuc_pkg::S_DSTORE;
					end
				end
				svuc_pkg::S_DSTORE: begin
					if (!axis_q) begin
						hx_q <= q_signed;
						axis_q <= 1'b1;
						state_q <= svuc_pkg::S_DLOAD;
					end else begin
						hy_q <= q_signed;
						state_q <= svuc_pkg::S_OUT;
					end
				end
				svuc_pkg::S_OUT: begin
					if (out_load) begin
						state_q <= svuc_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= svuc_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			nx_q <= new_x;
			ny_q <= new_y;
		end
		case (state_q)
			svuc_pkg::S_MAC: begin
				p_q <= prod;
				case (cnt_q)
					5'd1, 5'd3: acc_q <= p_q + HALF;
					5'd5: acc_q <= p_q;
					5'd6: acc_q <= blend_sum;
					default: begin
					end
				endcase
			end
			svuc_pkg::S_CHK: begin
				clamp_q <= len_gt;
				rad_q <= svuc_pkg::RAD_W'(len_sq) << (svuc_pkg::RAD_W - DW);
				rem_q <= '0;
				root_q <= '0;
			end
			svuc_pkg::S_SQRT: begin
				rem_q <= step_ge ? sub_d[RW-1:0] : sub_a[RW-1:0];
				root_q <= {root_q[RW-2:0], step_ge};
				rad_q <= rad_q << 2;
			end
			svuc_pkg::S_DLOAD: begin
				neg_q <= axis_val[SB-1];
				rem_q <= RW'(n_full[NW-1:SB]);
				dvd_q <= n_full[SB-1:0];
			end
			svuc_pkg::S_DIV: begin
				rem_q <= step_ge ? sub_d[RW-1:0] : sub_a[RW-1:0];
				dvd_q <= {dvd_q[SB-2:0], step_ge};
			end
			default: begin
			end
		endcase
		if (out_load) begin
			sx_q <= hx_q;
			sy_q <= hy_q;
			wc_q <= clamp_q;
		end
	end

	// The clamp only runs for a squared length above one, so the root has its top bit set.
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svuc_pkg::S_DLOAD) |-> root_q[RW-1])
		else $error("root below one at division start");

	// A normalized magnitude never exceeds one plus nothing: at most the sign-bit weight.
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svuc_pkg::S_DSTORE) |-> !(dvd_q[SB-1] && (|dvd_q[SB-2:0])))
		else $error("quotient out of range");

	// A result beat appears only from the final step of the sequencer.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == svuc_pkg::S_OUT))
		else $error("output loaded outside final step");

endmodule

// ===== test/smoothed_vector_with_unit_clamp_tb.sv =====
`timescale 1ns / 1ps

module smoothed_vector_with_unit_clamp_tb;

	localparam int SB = 16;
	localparam int FRAC = SB - 1;
	localparam int EXTRA = 31 - FRAC;
	localparam longint SAMPLE_MAX = (64'sd1 <<< FRAC) - 1;
	localparam longint SAMPLE_MIN = -(64'sd1 <<< FRAC);
	localparam int IDLE_PCT = 28;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 94;
	localparam int CALM_PHASE = 3;

	typedef logic signed [SB-1:0] sample_t;

	typedef struct packed {
		sample_t x;
		sample_t y;
		logic    clamped;
	} vec_out_t;

	// One directed beat, with an optional weight load in front of it.
	typedef struct packed {
		logic                          set_weight;
		logic [svuc_pkg::WEIGHT_W-1:0] weight;
		sample_t                       x;
		sample_t                       y;
		logic                          known;
		vec_out_t                      typed;
	} script_row_t;

	localparam int SCRIPT_LEN = 20;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		// Reset weight, zero input from the zero held vector.
		'{1'b0, 17'd0,      16'sh0000, 16'sh0000, 1'b1, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b0, 17'd0,      16'sh7FFF, 16'sh7FFF, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b0, 17'd0,      16'sh8000, 16'sh8000, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		// Weight zero passes the new sample straight through.
		'{1'b1, 17'd0,      16'sh7FFF, 16'sh0000, 1'b1, '{16'sh7FFF, 16'sh0000, 1'b0}},
		// Squared length exactly one is not clamped.
		'{1'b0, 17'd0,      16'sh8000, 16'sh0000, 1'b1, '{16'sh8000, 16'sh0000, 1'b0}},
		'{1'b0, 17'd0,      16'sh0000, 16'sh8000, 1'b1, '{16'sh0000, 16'sh8000, 1'b0}},
		// Just over one: the normalized magnitude saturates.
		'{1'b0, 17'd0,      16'sh8000, 16'sh0001, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b0, 17'd0,      16'sh8000, 16'sh8000, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b0, 17'd0,      16'sh7FFF, 16'sh7FFF, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b0, 17'd0,      16'sh0001, 16'shFFFF, 1'b1, '{16'sh0001, 16'shFFFF, 1'b0}},
		// Weight one holds the old vector whatever comes in.
		'{1'b1, 17'd65536,  16'sh7FFF, 16'sh8000, 1'b1, '{16'sh0001, 16'shFFFF, 1'b0}},
		'{1'b0, 17'd0,      16'sh8000, 16'sh7FFF, 1'b1, '{16'sh0001, 16'shFFFF, 1'b0}},
		// Weights above one saturate to one.
		'{1'b1, 17'h1FFFF,  16'sh3039, 16'shCFC7, 1'b1, '{16'sh0001, 16'shFFFF, 1'b0}},
		'{1'b1, 17'h10001,  16'shFFFF, 16'sh0000, 1'b1, '{16'sh0001, 16'shFFFF, 1'b0}},
		'{1'b1, 17'd1,      16'sh7FFF, 16'sh7FFF, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b1, 17'd65535,  16'sh8000, 16'sh8000, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b1, 17'd32768,  16'sh5A82, 16'sh5A82, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b0, 17'd0,      16'shA57E, 16'sh5A83, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b1, 17'd38011,  16'sh5555, 16'shAAAA, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}},
		'{1'b0, 17'd0,      16'sh7FFF, 16'sh8000, 1'b0, '{16'sh0000, 16'sh0000, 1'b0}}
	};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	sample_t                       new_x;
	sample_t                       new_y;
	logic                          out_valid;
	logic                          out_ready;
	sample_t                       smoothed_x;
	sample_t                       smoothed_y;
	logic                          was_clamped;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [svuc_pkg::WEIGHT_W-1:0] cfg_data;

	// Predictor copy of the held vector and the weight.
	sample_t                       track_x;
	sample_t                       track_y;
	logic [svuc_pkg::WEIGHT_W-1:0] track_weight;

	vec_out_t awaited_vectors[$];
	vec_out_t head_vec;
	logic     calm;
	int       faults;
	int       beats_sent;
	int       beats_checked;
	int       clamps_seen;
	int       weights_loaded;

	smoothed_vector_with_unit_clamp #(
		.SAMPLE_BITS(SB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.new_x(new_x),
		.new_y(new_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.smoothed_x(smoothed_x),
		.smoothed_y(smoothed_y),
		.was_clamped(was_clamped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Weighted blend of old and new value, rounded half up, clipped to the sample range.
	function automatic sample_t blend_axis(sample_t old_v, sample_t fresh_v,
			logic [svuc_pkg::WEIGHT_W-1:0] w);
		longint acc;
		acc = longint'(old_v) * longint'(w) +
			longint'(fresh_v) * (longint'(svuc_pkg::WEIGHT_ONE) - longint'(w));
		acc = (acc + 32768) >>> 16;
		if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
		if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
		return sample_t'(acc);
	endfunction

	// Bitwise integer square root, floor.
	function automatic longint unsigned root_of(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Divide one axis by the vector length, rounding the magnitude and saturating it.
	function automatic sample_t unit_axis(sample_t v, longint unsigned root);
		longint          sv;
		longint unsigned mag;
		longint unsigned q;
		sv = v;
		mag = (sv < 0) ? longint'(-sv) : longint'(sv);
		q = ((mag << (FRAC + EXTRA)) + (root >> 1)) / root;
		if (q > longint'(SAMPLE_MAX)) q = SAMPLE_MAX;
		return (sv < 0) ? sample_t'(-longint'(q)) : sample_t'(q);
	endfunction

	// Advance the predicted held vector by one sample and return the expected beat.
	function automatic vec_out_t smooth_sample(sample_t nx, sample_t ny);
		vec_out_t        res;
		longint unsigned len_sq;
		longint unsigned root;
		res.x = blend_axis(track_x, nx, track_weight);
		res.y = blend_axis(track_y, ny, track_weight);
		res.clamped = 1'b0;
		len_sq = longint'(res.x) * longint'(res.x) + longint'(res.y) * longint'(res.y);
		if (len_sq > (64'd1 << (2 * FRAC))) begin
			root = root_of(len_sq << (2 * EXTRA));
			res.x = unit_axis(res.x, root);
			res.y = unit_axis(res.y, root);
			res.clamped = 1'b1;
		end
		track_x = res.x;
		track_y = res.y;
		return res;
	endfunction

	// Random axis value: full range, small magnitudes, or corner values.
	function automatic sample_t pick_axis();
		int unsigned style;
		style = $urandom_range(0, 9);
		if (style < 5) return sample_t'($urandom);
		if (style < 8) return sample_t'(int'($urandom_range(0, 8191)) - 4096);
		case ($urandom_range(0, 6))
			0: return 16'sh8000;
			1: return 16'sh8001;
			2: return 16'shFFFF;
			3: return 16'sh0000;
			4: return 16'sh0001;
			5: return 16'sh7FFE;
			default: return 16'sh7FFF;
		endcase
	endfunction

	// Send one sample beat, with random gaps in front of it outside the calm phase, and record its expectation.
	task automatic push_sample(input sample_t x, input sample_t y, input logic use_typed,
			input vec_out_t typed);
		vec_out_t predicted;
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		new_x <= x;
		new_y <= y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = smooth_sample(x, y);
		awaited_vectors.push_back(use_typed ? typed : predicted);
		beats_sent++;
	endtask

	// Drain the block completely, then load a new sustain weight.
	task automatic load_weight(input logic [svuc_pkg::WEIGHT_W-1:0] w);
		in_valid <= 1'b0;
		while (awaited_vectors.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		track_weight = (w > svuc_pkg::WEIGHT_ONE) ? svuc_pkg::WEIGHT_ONE : w;
		weights_loaded++;
	endtask

	// Result side: compare each beat with the oldest expectation, stall at random outside the calm phase.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (awaited_vectors.size() == 0) begin
				$display("%0t: unexpected result beat x=%0d y=%0d clamped=%0b",
					$time, smoothed_x, smoothed_y, was_clamped);
				faults++;
			end else begin
				head_vec = awaited_vectors.pop_front();
				beats_checked++;
				if (was_clamped) clamps_seen++;
				if (smoothed_x !== head_vec.x) begin
					$display("%0t: smoothed_x expected %0d, got %0d",
						$time, head_vec.x, smoothed_x);
					faults++;
				end
				if (smoothed_y !== head_vec.y) begin
					$display("%0t: smoothed_y expected %0d, got %0d",
						$time, head_vec.y, smoothed_y);
					faults++;
				end
				if (was_clamped !== head_vec.clamped) begin
					$display("%0t: was_clamped expected %0b, got %0b",
						$time, head_vec.clamped, was_clamped);
					faults++;
				end
			end
		end
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Main sequence: reset, directed table, then random phases at several weights.
	initial begin
		vec_out_t                      none;
		logic [svuc_pkg::WEIGHT_W-1:0] w;
		none = '0;
		calm = 1'b0;
		faults = 0;
		beats_sent = 0;
		beats_checked = 0;
		clamps_seen = 0;
		weights_loaded = 0;
		track_x = '0;
		track_y = '0;
		track_weight = svuc_pkg::WEIGHT_RESET;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		new_x <= '0;
		new_y <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].set_weight) load_weight(SCRIPT[i].weight);
			push_sample(SCRIPT[i].x, SCRIPT[i].y, SCRIPT[i].known, SCRIPT[i].typed);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: w = svuc_pkg::WEIGHT_RESET;
				1: w = 17'd0;
				2: w = svuc_pkg::WEIGHT_ONE;
				3: w = 17'($urandom_range(0, 65536));
				4: w = 17'($urandom_range(1, 1023));
				5: w = 17'($urandom_range(64512, 65535));
				6: w = 17'h1FFFF;
				default: w = 17'($urandom);
			endcase
			load_weight(w);
			calm = (p == CALM_PHASE);
			for (int k = 0; k < PHASE_BEATS; k++) begin
				push_sample(pick_axis(), pick_axis(), 1'b0, none);
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (awaited_vectors.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d sample beats over %0d weight loads; %0d results checked, %0d clamped.",
			beats_sent, weights_loaded, beats_checked, clamps_seen);
		if (faults == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches found.", faults);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10_000_000;
		$display("Watchdog expired with %0d results outstanding.", awaited_vectors.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
